### design/dtte_pkg.sv
// Package for the date-time text to epoch nanoseconds block.
// Holds field widths, conversion constants, command struct and lookup functions.
// No dependencies.
package dtte_pkg;

  localparam int CHAR_W  = 8;
  localparam int EPOCH_W = 64;
  localparam int STAT_W  = 2;
  localparam int ZONE_W  = 17;

  // Parse field widths
  localparam int YEAR_W  = 14;
  localparam int FIELD_W = 7;
  localparam int FRAC_W  = 30;
  localparam int PHASE_W = 4;
  localparam int COUNT_W = 4;

  // Conversion widths
  localparam int T365_W = 22;
  localparam int DAYS_W = 22;
  localparam int DOY_W  = 9;
  localparam int TOD_W  = 19;
  localparam int SECS_W = 40;
  localparam int HALF_W = 20;

  // Parse phases
  localparam logic [PHASE_W-1:0] PH_YEAR   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_MONTH  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_DAY    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_HOUR   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_MINUTE = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SECOND = 4'd5;
  localparam logic [PHASE_W-1:0] PH_FRAC   = 4'd6;

  localparam logic [COUNT_W-1:0] YEAR_DIGITS_MAX = 4'd4;
  localparam logic [COUNT_W-1:0] FIELD_DIGITS    = 4'd2;
  localparam logic [COUNT_W-1:0] FRAC_DIGITS     = 4'd9;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FORMAT = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;

  // Arithmetic constants
  localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;
  localparam logic [19:0] DAY_OFS     = 20'd719468;
  localparam logic [8:0]  DAYS_YEAR   = 9'd365;
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [13:0] YEAR_MIN    = 14'd1970;

  typedef struct packed {
    logic consume;
    logic capture;
    logic calc_days;
    logic calc_secs;
    logic mul_lo;
    logic load_out;
  } dtte_cmd_t;

  // Separator that closes each field
  function automatic logic [CHAR_W-1:0] sep_char(input logic [PHASE_W-1:0] ph);
    logic [CHAR_W-1:0] c;
    unique case (ph)
      PH_YEAR, PH_MONTH:   c = 8'h2D;  // '-'
      PH_DAY:              c = 8'h20;  // ' '
      PH_HOUR, PH_MINUTE:  c = 8'h3A;  // ':'
      default:             c = 8'h2E;  // '.'
    endcase
    return c;
  endfunction

  // Place value of the fraction digit at position k (0 is tenths)
  function automatic logic [26:0] frac_weight(input logic [COUNT_W-1:0] k);
    logic [26:0] w;
    case (k)
      4'd0:    w = 27'd100000000;
      4'd1:    w = 27'd10000000;
      4'd2:    w = 27'd1000000;
      4'd3:    w = 27'd100000;
      4'd4:    w = 27'd10000;
      4'd5:    w = 27'd1000;
      4'd6:    w = 27'd100;
      4'd7:    w = 27'd10;
      4'd8:    w = 27'd1;
      default: w = 27'd0;
    endcase
    return w;
  endfunction

  // Days from March 1 to the first of the month, month counted from March
  function automatic logic [DOY_W-1:0] doy_base(input logic [FIELD_W-1:0] mp);
    logic [DOY_W-1:0] b;
    case (mp)
      7'd0:    b = 9'd0;
      7'd1:    b = 9'd31;
      7'd2:    b = 9'd61;
      7'd3:    b = 9'd92;
      7'd4:    b = 9'd122;
      7'd5:    b = 9'd153;
      7'd6:    b = 9'd184;
      7'd7:    b = 9'd214;
      7'd8:    b = 9'd245;
      7'd9:    b = 9'd275;
      7'd10:   b = 9'd306;
      7'd11:   b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

### design/dtte_in_if.sv
// Character input channel: valid/ready handshake with one text character.
// Depends on dtte_pkg.
interface dtte_in_if;
  logic                          valid;
  logic                          ready;
  logic [dtte_pkg::CHAR_W-1:0]   char_code;
  logic                          end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

### design/dtte_out_if.sv
// Result channel: valid/ready handshake with epoch nanoseconds and status.
// Depends on dtte_pkg.
interface dtte_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dtte_pkg::EPOCH_W-1:0] epoch_ns;
  logic [dtte_pkg::STAT_W-1:0]         status;

  modport source (output valid, output epoch_ns, output status, input ready);
  modport sink   (input valid, input epoch_ns, input status, output ready);
endinterface

### design/dtte_cfg_if.sv
// Configuration write channel: valid/ready handshake with the zone offset.
// Depends on dtte_pkg.
interface dtte_cfg_if;
  logic                               valid;
  logic                               ready;
  logic signed [dtte_pkg::ZONE_W-1:0] zone_offset_seconds;

  modport source (output valid, output zone_offset_seconds, input ready);
  modport sink   (input valid, input zone_offset_seconds, output ready);
endinterface

### design/datetime_text_to_epoch_ns.sv
// Top level of the date-time text to epoch nanoseconds block.
// Depends on dtte_pkg, the three channel interfaces, dtte_ctrl and dtte_dp.
//
// Feed the text "YYYY-MM-DD HH:MM:SS[.fraction]" one character per
// transaction, with end_of_text set on the last one. in_ready stays high
// for every character except the last. The last character starts the
// conversion (capture and range check, days since 1970, seconds with the
// zone offset, then the low and high halves of the nanosecond multiply, each
// a 20 bit by 30 bit product); in_ready stays low until it is done. If the
// previous result has not been taken yet, the last conversion step waits for
// it. Each timestamp gives exactly one result transaction; epoch_ns is zero
// unless status is 0.
// Write zone_offset_seconds only while no timestamp is in flight.
module datetime_text_to_epoch_ns (
  input  logic       clk,
  input  logic       rst_n,
  dtte_in_if.sink    in_ch,
  dtte_out_if.source out_ch,
  dtte_cfg_if.sink   cfg_ch
);
  import dtte_pkg::*;

  dtte_cmd_t cmd;

  // Config writes are always taken
  assign cfg_ch.ready = 1'b1;

  dtte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_end    (in_ch.end_of_text),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  dtte_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .char_code (in_ch.char_code),
    .cfg_we    (cfg_ch.valid),
    .cfg_zone  (cfg_ch.zone_offset_seconds),
    .epoch_ns  (out_ch.epoch_ns),
    .status    (out_ch.status)
  );

endmodule

### design/dtte_ctrl.sv
// Controller: sequences character parsing and the five-step epoch conversion.
// Owns the output valid flag. Depends on dtte_pkg.
module dtte_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_end,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output dtte_pkg::dtte_cmd_t cmd
);
  import dtte_pkg::*;

  localparam logic [2:0] S_PARSE = 3'd0;
  localparam logic [2:0] S_CAPT  = 3'd1;
  localparam logic [2:0] S_DAYS  = 3'd2;
  localparam logic [2:0] S_SECS  = 3'd3;
  localparam logic [2:0] S_MULLO = 3'd4;
  localparam logic [2:0] S_MULHI = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Decode commands from the current step
  always_comb begin
    cmd.consume   = (state_r == S_PARSE) && in_valid;
    cmd.capture   = (state_r == S_CAPT);
    cmd.calc_days = (state_r == S_DAYS);
    cmd.calc_secs = (state_r == S_SECS);
    cmd.mul_lo    = (state_r == S_MULLO);
    cmd.load_out  = (state_r == S_MULHI) && (!out_valid_r || out_ready);
  end

  // Advance through the conversion once the last character is taken
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_PARSE: if (in_valid && in_end) begin
        state_nxt = S_CAPT;
      end
      S_CAPT:  state_nxt = S_DAYS;
      S_DAYS:  state_nxt = S_SECS;
      S_SECS:  state_nxt = S_MULLO;
      S_MULLO: state_nxt = S_MULHI;
      S_MULHI: if (cmd.load_out) begin
        state_nxt = S_PARSE;
      end
      default: state_nxt = S_PARSE;
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_PARSE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_PARSE);
  assign out_valid = out_valid_r;

endmodule

### design/dtte_dp.sv
// Datapath: field accumulation, range checks, civil date to days, seconds and
// nanosecond scaling, zone register and result register. Depends on dtte_pkg.
module dtte_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dtte_pkg::dtte_cmd_t                 cmd,
  input  logic [dtte_pkg::CHAR_W-1:0]         char_code,
  input  logic                                cfg_we,
  input  logic signed [dtte_pkg::ZONE_W-1:0]  cfg_zone,
  output logic signed [dtte_pkg::EPOCH_W-1:0] epoch_ns,
  output logic [dtte_pkg::STAT_W-1:0]         status
);
  import dtte_pkg::*;

  // Parse state
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [FIELD_W-1:0] month_r, month_nxt;
  logic [FIELD_W-1:0] day_r, day_nxt;
  logic [FIELD_W-1:0] hour_r, hour_nxt;
  logic [FIELD_W-1:0] min_r, min_nxt;
  logic [FIELD_W-1:0] sec_r, sec_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic               ferr_r, ferr_nxt;
  logic [ZONE_W-1:0]  zone_r;

  // Conversion registers
  logic [STAT_W-1:0]  stat_r;
  logic [T365_W-1:0]  t365_r;
  logic [11:0]        q4_r;
  logic [6:0]         q100_r;
  logic [DOY_W-1:0]   doy_r;
  logic [TOD_W-1:0]   tod_r;
  logic [FRAC_W-1:0]  fcv_r;
  logic [DAYS_W-1:0]  days_r;
  logic [SECS_W-1:0]  secs_r;
  logic [EPOCH_W-1:0] acc_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [STAT_W-1:0]  status_r;

  logic               is_digit;
  logic [3:0]         dval;
  logic [COUNT_W-1:0] limit;
  logic [30:0]        frac_sum;

  // Classify the character
  always_comb begin
    is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
    dval     = char_code[3:0];
    limit    = (phase_r == PH_YEAR) ? YEAR_DIGITS_MAX : FIELD_DIGITS;
    frac_sum = 31'(frac_r) + 31'(dval) * 31'(frac_weight(count_r));
  end

  // Accumulate fields; latch a sticky error on anything malformed
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    frac_nxt  = frac_r;
    ferr_nxt  = ferr_r;
    if (cmd.capture) begin
      phase_nxt = PH_YEAR;
      count_nxt = '0;
      year_nxt  = '0;
      month_nxt = '0;
      day_nxt   = '0;
      hour_nxt  = '0;
      min_nxt   = '0;
      sec_nxt   = '0;
      frac_nxt  = '0;
      ferr_nxt  = 1'b0;
    end else if (cmd.consume && !ferr_r) begin
      if (phase_r < PH_FRAC) begin
        if (is_digit) begin
          if (count_r >= limit) begin
            ferr_nxt = 1'b1;
          end else begin
            count_nxt = count_r + 4'd1;
            case (phase_r)
              PH_YEAR:   year_nxt  = YEAR_W'(year_r * 14'd10 + 14'(dval));
              PH_MONTH:  month_nxt = FIELD_W'(month_r * 7'd10 + 7'(dval));
              PH_DAY:    day_nxt   = FIELD_W'(day_r * 7'd10 + 7'(dval));
              PH_HOUR:   hour_nxt  = FIELD_W'(hour_r * 7'd10 + 7'(dval));
              PH_MINUTE: min_nxt   = FIELD_W'(min_r * 7'd10 + 7'(dval));
              default:   sec_nxt   = FIELD_W'(sec_r * 7'd10 + 7'(dval));
            endcase
          end
        end else if ((char_code == sep_char(phase_r)) && (count_r != '0)) begin
          phase_nxt = phase_r + 4'd1;
          count_nxt = '0;
        end else begin
          ferr_nxt = 1'b1;
        end
      end else if (phase_r == PH_FRAC) begin
        if (!is_digit) begin
          ferr_nxt = 1'b1;
        end else if (count_r < FRAC_DIGITS) begin
          // Weight each digit by its place so short fractions come out padded
          frac_nxt  = frac_sum[FRAC_W-1:0];
          count_nxt = count_r + 4'd1;
        end
      end else begin
        ferr_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_YEAR;
      count_r <= '0;
      year_r  <= '0;
      month_r <= '0;
      day_r   <= '0;
      hour_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      frac_r  <= '0;
      ferr_r  <= 1'b0;
      zone_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      frac_r  <= frac_nxt;
      ferr_r  <= ferr_nxt;
      if (cfg_we) begin
        zone_r <= cfg_zone;
      end
    end
  end

  // Capture step: status, shifted year, month offset and time of day
  logic               complete;
  logic               in_range;
  logic [YEAR_W-1:0]  yy;
  logic [FIELD_W-1:0] mp;
  logic [26:0]        yy_recip;

  always_comb begin
    complete = ((phase_r == PH_SECOND) || (phase_r == PH_FRAC)) && (count_r != '0);
    in_range = (year_r >= YEAR_MIN) && (month_r >= 7'd1) && (month_r <= 7'd12) &&
               (day_r >= 7'd1) && (day_r <= 7'd31) && (hour_r <= 7'd23) &&
               (min_r <= 7'd59) && (sec_r <= 7'd59);
    yy       = (month_r <= 7'd2) ? year_r - 14'd1 : year_r;
    mp       = (month_r > 7'd2) ? month_r - 7'd3 : month_r + 7'd9;
    yy_recip = 27'(yy) * 27'(RECIP100);
  end

  // Conversion steps, one register stage each
  logic [22:0]          days_sum;
  logic [38:0]          day_secs;
  logic [49:0]          lo_prod;
  logic signed [50:0]   hi_prod;
  logic [EPOCH_W-1:0]   hi_term;

  always_comb begin
    days_sum = 23'(t365_r) + 23'(q4_r) + 23'(q100_r[6:2]) + 23'(doy_r)
             - 23'(q100_r) - 23'(DAY_OFS);
    day_secs = 39'(days_r) * 39'(SEC_PER_DAY);
    lo_prod  = 50'(secs_r[HALF_W-1:0]) * 50'(NS_PER_SEC);
    hi_prod  = $signed(secs_r[SECS_W-1:HALF_W]) * $signed({1'b0, NS_PER_SEC});
    hi_term  = {hi_prod[EPOCH_W-HALF_W-1:0], {HALF_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (ferr_r || !complete) begin
        stat_r <= ST_FORMAT;
      end else if (!in_range) begin
        stat_r <= ST_RANGE;
      end else begin
        stat_r <= ST_OK;
      end
      t365_r <= T365_W'(22'(yy) * 22'(DAYS_YEAR));
      q4_r   <= yy[YEAR_W-1:2];
      q100_r <= yy_recip[RECIP_SHIFT+6:RECIP_SHIFT];
      doy_r  <= DOY_W'(doy_base(mp) + 9'(day_r) - 9'd1);
      tod_r  <= TOD_W'(19'(hour_r) * 19'd3600 + 19'(min_r) * 19'd60 + 19'(sec_r));
      fcv_r  <= frac_r;
    end
    if (cmd.calc_days) begin
      days_r <= days_sum[DAYS_W-1:0];
    end
    if (cmd.calc_secs) begin
      secs_r <= 40'(day_secs) + 40'(tod_r) - {{(SECS_W-ZONE_W){zone_r[ZONE_W-1]}}, zone_r};
    end
    if (cmd.mul_lo) begin
      acc_r <= 64'(lo_prod) + 64'(fcv_r);
    end
    if (cmd.load_out) begin
      epoch_r  <= (stat_r == ST_OK) ? acc_r + hi_term : '0;
      status_r <= stat_r;
    end
  end

  assign epoch_ns = $signed(epoch_r);
  assign status   = status_r;

endmodule

### design/dtte_checker.sv
// Port-level checks for datetime_text_to_epoch_ns, attached by bind.
// Depends on dtte_pkg and the top level's channel ports.
module dtte_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_end,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [dtte_pkg::EPOCH_W-1:0] epoch_ns,
  input logic [dtte_pkg::STAT_W-1:0]         status
);
  import dtte_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(epoch_ns) && $stable(status))
    else $error("stalled result changed");

  // Stop taking characters after the last one of a timestamp
  a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end |=> !in_ready)
    else $error("character taken during conversion");

  // Keep taking characters inside a timestamp
  a_mid_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_end |=> in_ready)
    else $error("input stalled mid timestamp");

  // Zero the time on any error status, and never show an unused code
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((status == ST_OK) || ((status == ST_FORMAT || status == ST_RANGE)
                   && epoch_ns == '0)))
    else $error("bad status or nonzero time on error");

endmodule

bind datetime_text_to_epoch_ns dtte_checker u_dtte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_end    (in_ch.end_of_text),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .epoch_ns  (out_ch.epoch_ns),
  .status    (out_ch.status)
);
